// ----- hw/rtl/dwsi_pkg.sv -----
// Shared types and constants for the deque with sorted insert.
// No dependencies; imported by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package dwsi_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_REMOVE     = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_TAIL,
    S_SCAN,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/dwsi_req_if.sv -----
// Request channel: valid/ready handshake carrying an operation and a value.
// Depends on dwsi_pkg for field widths.
`timescale 1ns / 1ps

interface dwsi_req_if import dwsi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

// ----- hw/rtl/dwsi_rsp_if.sv -----
// Response channel: valid/ready handshake carrying status, taken value and fill level.
// Depends on dwsi_pkg for field widths.
`timescale 1ns / 1ps

interface dwsi_rsp_if import dwsi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] taken_value;
  logic [HELD_W-1:0]       entries_held;

  modport source (output valid, status, taken_value, entries_held, input ready);
  modport sink   (input valid, status, taken_value, entries_held, output ready);
endinterface

// ----- hw/rtl/deque_with_sorted_insert_top.sv -----
// Deque of up to DEPTH signed 32-bit values held in a circular single-port-read,
// single-port-write synchronous RAM. Every request beat yields one response beat.
// A sorted insert or remove-by-value may walk the entries: the RAM's one read port
// reads them one per cycle to find the place, then the same port plus the write port
// move the trailing entries by one slot, one per cycle. A new request is taken while
// the previous response still waits in the output register. No clearing pass.
// Depends on dwsi_pkg, dwsi_req_if and dwsi_rsp_if.
`timescale 1ns / 1ps

module deque_with_sorted_insert_top import dwsi_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwsi_req_if.sink    req_i,
  dwsi_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned XW = CW + HELD_W;

  // circular position -> physical slot; both operands below DEPTH (pos up to DEPTH)
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(pos);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic signed [VAL_W-1:0] store_q [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [AW-1:0]           mem_ra;
  logic signed [VAL_W-1:0] mem_wd;

  state_e                  state_q, state_d;
  logic [REQ_W-1:0]        req_q, req_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           front_q, front_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           pos_q, pos_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] taken_q, taken_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic signed [VAL_W-1:0] out_taken_q, out_taken_d;
  logic [HELD_W-1:0]       out_held_q, out_held_d;

  logic [CW-1:0] count_m1, count_p1, idx_m1, idx_m2, idx_p1;
  logic [SW-1:0] idx_p2w;
  logic [AW-1:0] front_dec;
  logic [XW-1:0] held_w;

  assign count_m1  = count_q - CW'(1);
  assign count_p1  = count_q + CW'(1);
  assign idx_m1    = idx_q - CW'(1);
  assign idx_m2    = idx_q - CW'(2);
  assign idx_p1    = idx_q + CW'(1);
  assign idx_p2w   = SW'(idx_q) + SW'(2);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign held_w    = XW'(count_q);

  // RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_wa] <= mem_wd;
    rdata_q <= store_q[mem_ra];
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    val_d        = val_q;
    count_d      = count_q;
    front_d      = front_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    status_d     = status_q;
    taken_d      = taken_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_taken_d  = out_taken_q;
    out_held_d   = out_held_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = val_q;
    mem_ra       = front_q;

    if (out_valid_q && rsp_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d    = req_i.req_type;
          val_d    = req_i.item_value;
          status_d = STS_OK;
          taken_d  = '0;
          state_d  = S_DONE;
          case (req_i.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
              mem_wd = req_i.item_value;
              if (count_q == CW'(DEPTH)) begin
                status_d = STS_FULL;
              end else if (count_q == '0) begin
                front_d = '0;
                mem_we  = 1'b1;
                mem_wa  = '0;
                count_d = count_p1;
              end else if (req_i.req_type == REQ_PUSH_FRONT) begin
                front_d = front_dec;
                mem_we  = 1'b1;
                mem_wa  = front_dec;
                count_d = count_p1;
              end else if (req_i.req_type == REQ_PUSH_BACK) begin
                mem_we  = 1'b1;
                mem_wa  = slot_f(front_q, count_q);
                count_d = count_p1;
              end else begin
                mem_ra  = front_q;
                state_d = S_HEAD;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else if (req_i.req_type == REQ_POP_BACK) begin
                mem_ra  = slot_f(front_q, count_m1);
                state_d = S_TAIL;
              end else begin
                mem_ra  = front_q;
                state_d = S_HEAD;
              end
            end
            default: ;
          endcase
        end
      end

      // rdata_q holds the head
      S_HEAD: begin
        if (req_q == REQ_INSERT && val_q < rdata_q) begin
          front_d = front_dec;
          mem_we  = 1'b1;
          mem_wa  = front_dec;
          count_d = count_p1;
          state_d = S_DONE;
        end else if (req_q == REQ_POP_FRONT ||
                     (req_q == REQ_REMOVE && rdata_q == val_q)) begin
          taken_d = rdata_q;
          count_d = count_m1;
          front_d = (count_m1 == '0) ? '0 : slot_f(front_q, CW'(1));
          state_d = S_DONE;
        end else begin
          mem_ra  = slot_f(front_q, count_m1);
          state_d = S_TAIL;
        end
      end

      // rdata_q holds the tail
      S_TAIL: begin
        if (req_q == REQ_INSERT) begin
          if (val_q > rdata_q || count_q == CW'(1)) begin
            mem_we  = 1'b1;
            mem_wa  = slot_f(front_q, count_q);
            count_d = count_p1;
            state_d = S_DONE;
          end else begin
            idx_d   = CW'(1);
            mem_ra  = slot_f(front_q, CW'(1));
            state_d = S_SCAN;
          end
        end else if (req_q == REQ_POP_BACK || rdata_q == val_q) begin
          taken_d = rdata_q;
          count_d = count_m1;
          if (count_m1 == '0) front_d = '0;
          state_d = S_DONE;
        end else if (count_q <= CW'(2)) begin
          status_d = STS_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d   = CW'(1);
          mem_ra  = slot_f(front_q, CW'(1));
          state_d = S_SCAN;
        end
      end

      // rdata_q holds entry idx_q; next read issued each cycle
      S_SCAN: begin
        if (req_q == REQ_INSERT) begin
          if (idx_q == count_m1 || !(val_q > rdata_q)) begin
            pos_d   = idx_q;
            idx_d   = count_q;
            mem_ra  = slot_f(front_q, count_m1);
            state_d = S_SHIFT_UP;
          end else begin
            idx_d  = idx_p1;
            mem_ra = slot_f(front_q, idx_p1);
          end
        end else begin
          if (rdata_q == val_q) begin
            taken_d = rdata_q;
            mem_ra  = slot_f(front_q, idx_p1);
            state_d = S_SHIFT_DN;
          end else if (idx_p2w < SW'(count_q)) begin
            idx_d  = idx_p1;
            mem_ra = slot_f(front_q, idx_p1);
          end else begin
            status_d = STS_NOT_FOUND;
            state_d  = S_DONE;
          end
        end
      end

      // rdata_q holds entry idx_q-1, moved up into idx_q
      S_SHIFT_UP: begin
        mem_we = 1'b1;
        mem_wa = slot_f(front_q, idx_q);
        mem_wd = rdata_q;
        if (idx_m1 == pos_q) begin
          state_d = S_PUT;
        end else begin
          idx_d  = idx_m1;
          mem_ra = slot_f(front_q, idx_m2);
        end
      end

      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = slot_f(front_q, pos_q);
        mem_wd  = val_q;
        count_d = count_p1;
        state_d = S_DONE;
      end

      // rdata_q holds entry idx_q+1, moved down into idx_q
      S_SHIFT_DN: begin
        mem_we = 1'b1;
        mem_wa = slot_f(front_q, idx_q);
        mem_wd = rdata_q;
        if (idx_p2w < SW'(count_q)) begin
          idx_d  = idx_p1;
          mem_ra = slot_f(front_q, CW'(idx_p2w));
        end else begin
          count_d = count_m1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_taken_d  = taken_q;
          out_held_d   = held_w[HELD_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      front_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      front_q     <= front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    status_q     <= status_d;
    taken_q      <= taken_d;
    out_status_q <= out_status_d;
    out_taken_q  <= out_taken_d;
    out_held_q   <= out_held_d;
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.taken_value  = out_taken_q;
  assign rsp_o.entries_held = out_held_q;

endmodule

// ----- hw/rtl/dwsi_checker.sv -----
// Port-level checks for deque_with_sorted_insert_top, attached by bind.
// Depends on dwsi_pkg.
`timescale 1ns / 1ps

module dwsi_checker import dwsi_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [STATUS_W-1:0]     status_i,
  input logic signed [VAL_W-1:0] taken_i,
  input logic [HELD_W-1:0]       held_i
);

  localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(DEPTH);

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(taken_i) && $stable(held_i))
    else $error("response beat changed while stalled");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == STS_FULL |-> held_i == FULL_HELD && taken_i == '0)
    else $error("full response with wrong fill level or value");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == STS_EMPTY |-> held_i == '0 && taken_i == '0)
    else $error("empty response with nonzero fill level or value");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one still at work");

endmodule

bind deque_with_sorted_insert_top dwsi_checker #(.DEPTH(DEPTH)) u_dwsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .taken_i     (rsp_o.taken_value),
  .held_i      (rsp_o.entries_held)
);
